/* hdl/stack_machine_core_assert.svh */
// Assertion helpers for the stack machine core.
// Both forms sample on clk and are disabled while rst is high.
`ifndef STACK_MACHINE_CORE_ASSERT_SVH
`define STACK_MACHINE_CORE_ASSERT_SVH

// Same-cycle implication
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/smc_pkg.sv */
`timescale 1ns / 1ps
package smc_pkg;

  localparam int CMD_W  = 8;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;

  // Opcodes
  localparam logic [CMD_W-1:0] OP_PUSH  = 8'd0;
  localparam logic [CMD_W-1:0] OP_POP   = 8'd1;
  localparam logic [CMD_W-1:0] OP_ADD   = 8'd2;
  localparam logic [CMD_W-1:0] OP_SUB   = 8'd3;
  localparam logic [CMD_W-1:0] OP_JMP   = 8'd4;
  localparam logic [CMD_W-1:0] OP_JZ    = 8'd5;
  localparam logic [CMD_W-1:0] OP_LOAD  = 8'd6;
  localparam logic [CMD_W-1:0] OP_STORE = 8'd7;
  localparam logic [CMD_W-1:0] OP_CALL  = 8'd8;
  localparam logic [CMD_W-1:0] OP_RET   = 8'd9;
  localparam logic [CMD_W-1:0] OP_HALT  = 8'd10;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_HALTED    = 3'd1,
    ST_BAD_OP    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_BAD_INDEX = 3'd5,
    ST_BAD_ADDR  = 3'd6,
    ST_STOPPED   = 3'd7
  } smc_status_t;

endpackage

/* hdl/smc_cmd_if.sv */
`timescale 1ns / 1ps
// Instruction channel: opcode plus the program word after it
interface smc_cmd_if;
  import smc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, cmd, operand, input ready);
  modport sink   (input valid, cmd, operand, output ready);
endinterface

/* hdl/smc_res_if.sv */
`timescale 1ns / 1ps
// Result channel: machine state after one instruction
interface smc_res_if #(
  parameter int PC_W  = 10,
  parameter int CNT_W = 9
);
  import smc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_pc;
  logic signed [DATA_W-1:0] top_value;
  logic [CNT_W-1:0]         stack_depth;
  logic [STAT_W-1:0]        status;

  modport source (output valid, next_pc, top_value, stack_depth, status, input ready);
  modport sink   (input valid, next_pc, top_value, stack_depth, status, output ready);
endinterface

/* hdl/smc_ram.sv */
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data
module smc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/stack_machine_core.sv */
`timescale 1ns / 1ps
// Stack machine core: executes one instruction per transaction on instr and returns
// one transaction on result holding the next fetch address, the top of stack (zero
// when empty), the stack depth and a status code. Every instruction runs through
// the same fixed sequence, paced by the single read port of the stack RAM: read
// the top entry (or the load source), read the entry under it, execute and write
// back, read the new top, deliver. The next instruction is accepted only once the
// result has been handed to the result register; it may be taken while the
// previous result still waits to be taken. A fault or halt sets the stopped
// flag; after that every instruction returns the unchanged state with status
// "already stopped" until reset. The stack RAM needs no clearing after reset.
module stack_machine_core #(
  parameter int STACK_DEPTH = 256,
  parameter int PROG_WORDS  = 1024
) (
  input  logic       clk,
  input  logic       rst,
  smc_cmd_if.sink    instr,
  smc_res_if.source  result
);
  import smc_pkg::*;

  `include "stack_machine_core_assert.svh"

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int PW = $clog2(PROG_WORDS);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ISSUE   = 7'b0000010,
    S_FETCH_A = 7'b0000100,
    S_FETCH_B = 7'b0001000,
    S_EXEC    = 7'b0010000,
    S_TOP_RD  = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Architectural state
  logic [CW-1:0] count;
  logic [PW-1:0] pc;
  logic          stopped;

  // Latched instruction and operands
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] opd_r;
  logic [DATA_W-1:0] a_r;   // top entry, or load source
  logic [DATA_W-1:0] b_r;   // entry under the top
  smc_status_t       step_status;  // status of the instruction in flight

  // Result register
  logic              res_valid;
  logic [PW-1:0]     res_pc;
  logic [DATA_W-1:0] res_top;
  logic [CW-1:0]     res_depth;
  smc_status_t       res_status;

  // Stack RAM ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  smc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshakes
  logic accept;
  logic load_out;
  assign instr.ready = (state == S_IDLE);
  assign accept      = instr.valid && instr.ready;
  assign load_out    = (state == S_FINISH) && (!res_valid || result.ready);

  // Stack pointers below the top
  logic [CW-1:0] cnt_dec1;
  logic [CW-1:0] cnt_dec2;
  assign cnt_dec1 = count - CW'(1);
  assign cnt_dec2 = count - CW'(2);

  // Sequential program counter advance, wrapping at PROG_WORDS
  logic [PW:0]   pc_sum1;
  logic [PW:0]   pc_sum2;
  logic [PW-1:0] adv1;
  logic [PW-1:0] adv2;
  assign pc_sum1 = {1'b0, pc} + (PW + 1)'(1);
  assign pc_sum2 = {1'b0, pc} + (PW + 1)'(2);
  assign adv1 = (pc_sum1 >= (PW + 1)'(PROG_WORDS)) ?
                PW'(pc_sum1 - (PW + 1)'(PROG_WORDS)) : pc_sum1[PW-1:0];
  assign adv2 = (pc_sum2 >= (PW + 1)'(PROG_WORDS)) ?
                PW'(pc_sum2 - (PW + 1)'(PROG_WORDS)) : pc_sum2[PW-1:0];

  // Shared add/subtract unit
  logic [DATA_W-1:0] alu_out;
  assign alu_out = (cmd_r == OP_SUB) ? (b_r - a_r) : (b_r + a_r);

  // Range checks on stack depth, operand and top entry
  logic is_empty, lt_two, is_full, idx_ok, opd_addr_ok, top_addr_ok;
  assign is_empty    = (count == '0);
  assign lt_two      = (count < CW'(2));
  assign is_full     = (count >= CW'(STACK_DEPTH));
  assign idx_ok      = !opd_r[DATA_W-1] &&
                       ({1'b0, opd_r[DATA_W-2:0]} < DATA_W'(count));
  assign opd_addr_ok = !opd_r[DATA_W-1] && (opd_r[DATA_W-2:0] < (DATA_W - 1)'(PROG_WORDS));
  assign top_addr_ok = !a_r[DATA_W-1] && (a_r[DATA_W-2:0] < (DATA_W - 1)'(PROG_WORDS));

  // Execute decision
  smc_status_t       ex_status;
  logic              ex_wr;
  logic [AW-1:0]     ex_waddr;
  logic [DATA_W-1:0] ex_wdata;
  logic [CW-1:0]     ex_count;
  logic [PW-1:0]     ex_pc;

  always_comb begin
    ex_status = ST_OK;
    ex_wr     = 1'b0;
    ex_waddr  = count[AW-1:0];
    ex_wdata  = opd_r;
    ex_count  = count;
    ex_pc     = pc;
    if (stopped) begin
      ex_status = ST_STOPPED;
    end else begin
      unique case (cmd_r)
        OP_PUSH: begin
          if (is_full) begin
            ex_status = ST_OVERFLOW;
          end else begin
            ex_wr    = 1'b1;
            ex_count = count + CW'(1);
            ex_pc    = adv2;
          end
        end
        OP_POP: begin
          if (is_empty) begin
            ex_status = ST_UNDERFLOW;
          end else begin
            ex_count = cnt_dec1;
            ex_pc    = adv1;
          end
        end
        OP_ADD, OP_SUB: begin
          if (lt_two) begin
            ex_status = ST_UNDERFLOW;
          end else begin
            ex_wr    = 1'b1;
            ex_waddr = cnt_dec2[AW-1:0];
            ex_wdata = alu_out;
            ex_count = cnt_dec1;
            ex_pc    = adv1;
          end
        end
        OP_JMP: begin
          if (!opd_addr_ok) begin
            ex_status = ST_BAD_ADDR;
          end else begin
            ex_pc = opd_r[PW-1:0];
          end
        end
        OP_JZ: begin
          if (is_empty) begin
            ex_status = ST_UNDERFLOW;
          end else if (a_r == '0) begin
            if (!opd_addr_ok) begin
              ex_status = ST_BAD_ADDR;
            end else begin
              ex_pc    = opd_r[PW-1:0];
              ex_count = cnt_dec1;
            end
          end else begin
            ex_pc    = adv2;
            ex_count = cnt_dec1;
          end
        end
        OP_LOAD: begin
          if (!idx_ok) begin
            ex_status = ST_BAD_INDEX;
          end else if (is_full) begin
            ex_status = ST_OVERFLOW;
          end else begin
            ex_wr    = 1'b1;
            ex_wdata = a_r;
            ex_count = count + CW'(1);
            ex_pc    = adv2;
          end
        end
        OP_STORE: begin
          if (is_empty) begin
            ex_status = ST_UNDERFLOW;
          end else if (!idx_ok) begin
            ex_status = ST_BAD_INDEX;
          end else begin
            ex_wr    = 1'b1;
            ex_waddr = opd_r[AW-1:0];
            ex_wdata = a_r;
            ex_count = cnt_dec1;
            ex_pc    = adv2;
          end
        end
        OP_CALL: begin
          if (is_full) begin
            ex_status = ST_OVERFLOW;
          end else if (!opd_addr_ok) begin
            ex_status = ST_BAD_ADDR;
          end else begin
            ex_wr    = 1'b1;
            ex_wdata = DATA_W'(adv2);
            ex_count = count + CW'(1);
            ex_pc    = opd_r[PW-1:0];
          end
        end
        OP_RET: begin
          if (is_empty) begin
            ex_status = ST_UNDERFLOW;
          end else if (!top_addr_ok) begin
            ex_status = ST_BAD_ADDR;
          end else begin
            ex_pc    = a_r[PW-1:0];
            ex_count = cnt_dec1;
          end
        end
        OP_HALT: begin
          ex_status = ST_HALTED;
          ex_pc     = adv1;
        end
        default: begin
          ex_status = ST_BAD_OP;
        end
      endcase
    end
  end

  // RAM access per sequencer step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_dec1[AW-1:0];
    unique case (state)
      S_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = (cmd_r == OP_LOAD) ? opd_r[AW-1:0] : cnt_dec1[AW-1:0];
      end
      S_FETCH_A: begin
        rd_en   = 1'b1;
        rd_addr = cnt_dec2[AW-1:0];
      end
      S_TOP_RD: begin
        rd_en   = 1'b1;
        rd_addr = cnt_dec1[AW-1:0];
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign wr_en   = (state == S_EXEC) && ex_wr;
  assign wr_addr = ex_waddr;
  assign wr_data = ex_wdata;

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept) state_next = S_ISSUE;
      S_ISSUE:   state_next = S_FETCH_A;
      S_FETCH_A: state_next = S_FETCH_B;
      S_FETCH_B: state_next = S_EXEC;
      S_EXEC:    state_next = S_TOP_RD;
      S_TOP_RD:  state_next = S_FINISH;
      S_FINISH:  if (load_out) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pc        <= '0;
      stopped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        count   <= ex_count;
        pc      <= ex_pc;
        stopped <= (ex_status != ST_OK);
      end
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= instr.cmd;
      opd_r <= instr.operand;
    end
    if (state == S_FETCH_A) begin
      a_r <= rd_data;
    end
    if (state == S_FETCH_B) begin
      b_r <= rd_data;
    end
    // held here so a waiting result keeps its own status
    if (state == S_EXEC) begin
      step_status <= ex_status;
    end
    if (load_out) begin
      res_pc     <= pc;
      res_top    <= is_empty ? '0 : rd_data;
      res_depth  <= count;
      res_status <= step_status;
    end
  end

  assign result.valid       = res_valid;
  assign result.next_pc     = res_pc;
  assign result.top_value   = res_top;
  assign result.stack_depth = res_depth;
  assign result.status      = res_status;

  // Checks
  `SMC_ASSERT_NXT(a_stopped_sticky, stopped, stopped, "stopped flag cleared without reset")
  `SMC_ASSERT_IMP(a_depth_bound, 1'b1, count <= CW'(STACK_DEPTH), "stack depth out of range")
  `SMC_ASSERT_IMP(a_no_write_stopped, (state == S_EXEC) && stopped, !wr_en,
                  "stack written while stopped")
  `SMC_ASSERT_NXT(a_status_matches_stop, load_out,
                  (result.status == ST_OK) == !stopped,
                  "result status disagrees with stopped flag")

endmodule

/* verif/stack_machine_core_tb.sv */
`timescale 1ns / 1ps
module stack_machine_core_tb;
  import smc_pkg::*;

  localparam int STACK_SIZE = 256;
  localparam int PROG_SIZE  = 1024;
  localparam int RAND_ITEMS = 600;

  // Machine state as seen on the result channel
  typedef struct packed {
    logic [9:0]  pc;
    logic [31:0] top;
    logic [8:0]  depth;
    smc_status_t status;
  } machine_view_t;

  typedef struct packed {
    logic [7:0]    op;
    logic [31:0]   word;
    bit            typed;
    machine_view_t view;
  } dir_row_t;

  typedef enum {F_HALT, F_BAD_OP, F_UNDER, F_OVER, F_INDEX, F_ADDR} fault_kind_t;

  localparam logic [7:0] LEGAL_OPS [10] = '{OP_PUSH, OP_POP, OP_ADD, OP_SUB, OP_JMP,
                                            OP_JZ, OP_LOAD, OP_STORE, OP_CALL, OP_RET};
  localparam logic [7:0] UNDER_OPS [6]  = '{OP_POP, OP_JZ, OP_STORE, OP_RET, OP_ADD, OP_SUB};

  // Directed program: wrap of add/sub, pc wrap, jz both ways, load/store, call/return
  localparam int DIR_ROWS = 19;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{OP_PUSH,  32'h7FFF_FFFF, 1'b1, '{10'd2,    32'h7FFF_FFFF, 9'd1, ST_OK}},
    '{OP_PUSH,  32'h0000_0001, 1'b0, '0},
    '{OP_ADD,   32'h0000_0000, 1'b1, '{10'd5,    32'h8000_0000, 9'd1, ST_OK}},
    '{OP_PUSH,  32'h8000_0000, 1'b0, '0},
    '{OP_PUSH,  32'h0000_0001, 1'b0, '0},
    '{OP_SUB,   32'hFFFF_FFFF, 1'b1, '{10'd10,   32'h7FFF_FFFF, 9'd2, ST_OK}},
    '{OP_JMP,   32'd1023,      1'b1, '{10'd1023, 32'h7FFF_FFFF, 9'd2, ST_OK}},
    '{OP_PUSH,  32'h0000_0000, 1'b1, '{10'd1,    32'h0000_0000, 9'd3, ST_OK}},
    '{OP_JZ,    32'd1022,      1'b0, '0},
    '{OP_PUSH,  32'hFFFF_FFFF, 1'b1, '{10'd0,    32'hFFFF_FFFF, 9'd3, ST_OK}},
    '{OP_JZ,    32'h8000_0000, 1'b1, '{10'd2,    32'h7FFF_FFFF, 9'd2, ST_OK}},
    '{OP_LOAD,  32'h0000_0000, 1'b0, '0},
    '{OP_STORE, 32'h0000_0001, 1'b0, '0},
    '{OP_CALL,  32'd1023,      1'b1, '{10'd1023, 32'h0000_0008, 9'd3, ST_OK}},
    '{OP_RET,   32'h0000_0000, 1'b0, '0},
    '{OP_CALL,  32'h0000_0000, 1'b0, '0},
    '{OP_RET,   32'hFFFF_FFFF, 1'b0, '0},
    '{OP_POP,   32'h0000_0000, 1'b0, '0},
    '{OP_POP,   32'h0000_0000, 1'b1, '{10'd12,   32'h0000_0000, 9'd0, ST_OK}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  smc_cmd_if instr_ch();
  smc_res_if #(.PC_W(10), .CNT_W(9)) result_ch();

  stack_machine_core #(
    .STACK_DEPTH(STACK_SIZE),
    .PROG_WORDS (PROG_SIZE)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .instr (instr_ch),
    .result(result_ch)
  );

  // Predicted machine state
  logic [31:0] stk_mem [STACK_SIZE];
  int          stk_count = 0;
  logic [9:0]  pc_reg = '0;
  bit          stopped = 1'b0;

  machine_view_t after_state_q[$];
  machine_view_t seen_view;
  int          tx_idle_pct = 9;
  int          rx_idle_pct = 47;
  int          mismatches = 0;
  int          instrs_sent = 0;
  int          results_seen = 0;
  fault_kind_t fault_kind;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit addr_ok(input logic [31:0] w);
    return !w[31] && (w < PROG_SIZE);
  endfunction

  // Executes one instruction on the predicted state and returns the resulting view
  function automatic machine_view_t execute_instr(input logic [7:0] op, input logic [31:0] w);
    machine_view_t v;
    smc_status_t   st;
    logic [9:0]    npc;
    int            n;
    st  = ST_OK;
    npc = pc_reg;
    n   = stk_count;
    if (stopped) begin
      st = ST_STOPPED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (n >= STACK_SIZE) st = ST_OVERFLOW;
          else begin
            stk_mem[n] = w;
            stk_count  = n + 1;
            npc        = pc_reg + 10'd2;
          end
        end
        OP_POP: begin
          if (n < 1) st = ST_UNDERFLOW;
          else begin
            stk_count = n - 1;
            npc       = pc_reg + 10'd1;
          end
        end
        OP_ADD, OP_SUB: begin
          if (n < 2) st = ST_UNDERFLOW;
          else begin
            stk_mem[n-2] = (op == OP_ADD) ? stk_mem[n-2] + stk_mem[n-1]
                                          : stk_mem[n-2] - stk_mem[n-1];
            stk_count    = n - 1;
            npc          = pc_reg + 10'd1;
          end
        end
        OP_JMP: begin
          if (!addr_ok(w)) st = ST_BAD_ADDR;
          else npc = w[9:0];
        end
        OP_JZ: begin
          if (n < 1) st = ST_UNDERFLOW;
          else if (stk_mem[n-1] != 32'h0) begin
            npc       = pc_reg + 10'd2;
            stk_count = n - 1;
          end else if (!addr_ok(w)) st = ST_BAD_ADDR;
          else begin
            npc       = w[9:0];
            stk_count = n - 1;
          end
        end
        OP_LOAD: begin
          // index is checked ahead of the depth limit
          if (w[31] || w >= n) st = ST_BAD_INDEX;
          else if (n >= STACK_SIZE) st = ST_OVERFLOW;
          else begin
            stk_mem[n] = stk_mem[int'(w)];
            stk_count  = n + 1;
            npc        = pc_reg + 10'd2;
          end
        end
        OP_STORE: begin
          if (n < 1) st = ST_UNDERFLOW;
          else if (w[31] || w >= n) st = ST_BAD_INDEX;
          else begin
            stk_mem[int'(w)] = stk_mem[n-1];
            stk_count        = n - 1;
            npc              = pc_reg + 10'd2;
          end
        end
        OP_CALL: begin
          if (n >= STACK_SIZE) st = ST_OVERFLOW;
          else if (!addr_ok(w)) st = ST_BAD_ADDR;
          else begin
            stk_mem[n] = {22'd0, pc_reg + 10'd2};
            stk_count  = n + 1;
            npc        = w[9:0];
          end
        end
        OP_RET: begin
          if (n < 1) st = ST_UNDERFLOW;
          else if (!addr_ok(stk_mem[n-1])) st = ST_BAD_ADDR;
          else begin
            npc       = stk_mem[n-1][9:0];
            stk_count = n - 1;
          end
        end
        OP_HALT: begin
          st  = ST_HALTED;
          npc = pc_reg + 10'd1;
        end
        default: st = ST_BAD_OP;
      endcase
      if (st != ST_OK) stopped = 1'b1;
      pc_reg = npc;
    end
    v.pc     = pc_reg;
    v.top    = (stk_count > 0) ? stk_mem[stk_count-1] : 32'h0;
    v.depth  = 9'(stk_count);
    v.status = st;
    return v;
  endfunction

  // Push data biased toward zero and valid addresses so jz and ret get exercised
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0, 1:    return 32'h0;
      2, 3:    return $urandom_range(0, PROG_SIZE - 1);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'hFFFF_FFFF;
          default: return 32'h1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Drive one instruction, wait for the transaction, then record the predicted state
  task automatic issue_instr(input logic [7:0] op, input logic [31:0] w);
    machine_view_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    instr_ch.valid   <= 1'b1;
    instr_ch.cmd     <= op;
    instr_ch.operand <= w;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    predicted = execute_instr(op, w);
    after_state_q.insert(after_state_q.size(), predicted);
    instrs_sent++;
    @(negedge clk);
  endtask

  // Choose an instruction that keeps the machine running
  task automatic pick_legal(output logic [7:0] op, output logic [31:0] w);
    bit ok;
    bit grow;
    ok = 1'b0;
    while (!ok) begin
      op   = LEGAL_OPS[$urandom_range(0, 9)];
      w    = $urandom();
      // keep the stack shallow most of the time
      grow = (stk_count < STACK_SIZE) && (stk_count < 16 || $urandom_range(0, 3) == 0);
      case (op)
        OP_PUSH: begin
          ok = grow;
          w  = rand_word();
        end
        OP_POP:         ok = (stk_count >= 1);
        OP_ADD, OP_SUB: ok = (stk_count >= 2);
        OP_JMP: begin
          ok = 1'b1;
          w  = $urandom_range(0, PROG_SIZE - 1);
        end
        OP_JZ: begin
          // a not-taken jz may carry any word
          ok = (stk_count >= 1);
          if (ok && (stk_mem[stk_count-1] == 32'h0 || $urandom_range(0, 1) == 0))
            w = $urandom_range(0, PROG_SIZE - 1);
        end
        OP_LOAD: begin
          ok = grow && (stk_count >= 1);
          if (ok) w = $urandom_range(0, stk_count - 1);
        end
        OP_STORE: begin
          ok = (stk_count >= 1);
          if (ok) w = $urandom_range(0, stk_count - 1);
        end
        OP_CALL: begin
          ok = grow;
          w  = $urandom_range(0, PROG_SIZE - 1);
        end
        OP_RET:  ok = (stk_count >= 1) && addr_ok(stk_mem[stk_count-1]);
        default: ok = 1'b0;
      endcase
    end
  endtask

  // Bring the machine into one fault, then feed it instructions it must ignore
  task automatic end_with_fault();
    logic [7:0]  op;
    logic [31:0] w;
    int          target;
    fault_kind = fault_kind_t'($urandom_range(0, 5));
    case (fault_kind)
      F_HALT:   issue_instr(OP_HALT, $urandom());
      F_BAD_OP: issue_instr(8'($urandom_range(11, 255)), $urandom());
      F_UNDER: begin
        target = $urandom_range(0, 1);
        while (stk_count > target) issue_instr(OP_POP, $urandom());
        if (stk_count == 0) op = UNDER_OPS[$urandom_range(0, 5)];
        else op = ($urandom_range(0, 1) == 1) ? OP_ADD : OP_SUB;
        issue_instr(op, $urandom());
      end
      F_OVER: begin
        while (stk_count < STACK_SIZE) issue_instr(OP_PUSH, rand_word());
        case ($urandom_range(0, 2))
          0:       issue_instr(OP_PUSH, $urandom());
          1:       issue_instr(OP_LOAD, $urandom_range(0, STACK_SIZE - 1));
          default: issue_instr(OP_CALL, $urandom());
        endcase
      end
      F_INDEX: begin
        if (stk_count == 0) issue_instr(OP_PUSH, rand_word());
        case ($urandom_range(0, 2))
          0:       w = stk_count;
          1:       w = $urandom_range(stk_count, 32'h7FFF_FFFF);
          default: w = $urandom() | 32'h8000_0000;
        endcase
        issue_instr(($urandom_range(0, 1) == 1) ? OP_LOAD : OP_STORE, w);
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       w = 32'd1024;
          1:       w = $urandom_range(1025, 32'h7FFF_FFFF);
          default: w = $urandom() | 32'h8000_0000;
        endcase
        if (stk_count == STACK_SIZE) issue_instr(OP_POP, $urandom());
        case ($urandom_range(0, 3))
          0: issue_instr(OP_JMP, w);
          1: issue_instr(OP_CALL, w);
          2: begin
            issue_instr(OP_PUSH, 32'h0);
            issue_instr(OP_JZ, w);
          end
          default: begin
            issue_instr(OP_PUSH, w);
            issue_instr(OP_RET, $urandom());
          end
        endcase
      end
    endcase
    // stopped machine: all opcode bits toggle here
    issue_instr(8'hFF, 32'hFFFF_FFFF);
    issue_instr(8'h00, 32'h0);
    repeat (8) issue_instr(8'($urandom_range(0, 255)), $urandom());
  endtask

  task automatic flag_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // Result receiver: random backpressure
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Compare each result transaction with the oldest predicted state
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (after_state_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual pc %h top %h depth %0d status %0d",
                 $time, result_ch.next_pc, result_ch.top_value, result_ch.stack_depth,
                 result_ch.status);
      end else begin
        seen_view = after_state_q.pop_front();
        flag_field("next_pc", 32'(seen_view.pc), 32'(result_ch.next_pc));
        flag_field("top_value", seen_view.top, result_ch.top_value);
        flag_field("stack_depth", 32'(seen_view.depth), 32'(result_ch.stack_depth));
        flag_field("status", 32'(seen_view.status), 32'(result_ch.status));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [7:0]  op;
    logic [31:0] w;
    instr_ch.valid   = 1'b0;
    instr_ch.cmd     = '0;
    instr_ch.operand = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      issue_instr(DIRECTED[i].op, DIRECTED[i].word);
      if (DIRECTED[i].typed) after_state_q[after_state_q.size() - 1] = DIRECTED[i].view;
    end

    // three idle mixes: slow receiver, slow sender, none
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 47 : 0;
      rx_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 9 : 0;
      for (int i = 0; i < RAND_ITEMS / 3; i++) begin
        pick_legal(op, w);
        issue_instr(op, w);
      end
    end
    end_with_fault();
    instr_ch.valid <= 1'b0;

    while (after_state_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d instructions (%0d directed) and checked %0d results",
             instrs_sent, DIR_ROWS, results_seen);
    $display("Random program under three idle mixes, ending in a %s fault",
             fault_kind.name());
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
